FILE: rtl/sps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the systolic prime sieve
// no dependencies

package sps_pkg;

  localparam int NUM_STAGES_DEF = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CAND_W         = 16;
  localparam int EXT_W          = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one bit of the candidate moving down the cell row
  typedef struct packed {
    logic vld;
    logic dbit;
    logic first;
    logic last;
    logic hit;
    logic stored;
  } step_t;

endpackage

FILE: rtl/systolic_prime_sieve_core.sv
`timescale 1ns / 1ps
// top level of the systolic prime sieve: sequencer plus a row of sieve cells
// depends on sps_pkg and sps_cell
//
// A candidate of 2 or more is shifted msb first into a row of NUM_STAGES cells, one bit
// per cycle, and each cell folds the bits into a remainder against its stored value while
// handing them on to the next cell. The verdict reaches the sequencer through the register
// of every cell after the last bit goes in. No new candidate is taken before that verdict
// is back and, for a surviving candidate, its result is loaded into the output register;
// a dropped candidate gives no beat out. A candidate below 2 is taken with no beat out,
// and an end-of-stream beat clears all cells at once, and its marker is loaded into the
// output register from the done state before the next beat is taken. A finished result
// waits in the output register while the next candidate is taken; a new result that
// finds that register still full holds the sequencer until it drains.

module systolic_prime_sieve_core #(
  parameter int NUM_STAGES = sps_pkg::NUM_STAGES_DEF,
  parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // candidate[15:0]
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // prime_value[15:0]
  output logic        m_tuser,   // overflow
  output logic        m_tlast    // end_marker
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  sps_pkg::state_t state, state_next;
  sps_pkg::step_t  chain [NUM_STAGES+1];
  sps_pkg::step_t  head;
  sps_pkg::step_t  tail;

  logic [VALUE_BITS-1:0]   shreg;
  logic [VALUE_BITS-1:0]   cand_q;
  logic [CNT_W-1:0]        bit_cnt;
  logic                    res_overflow;
  logic                    res_end;

  logic [sps_pkg::EXT_W-1:0] cand_ext;
  logic [sps_pkg::EXT_W-1:0] res_ext;
  logic [VALUE_BITS-1:0]     cand_v;
  logic                      accept;
  logic                      clear;
  logic                      load_out;
  logic                      last_bit;

  assign cand_ext = {{(sps_pkg::EXT_W-sps_pkg::CAND_W){1'b0}}, s_tdata};
  assign cand_v   = cand_ext[VALUE_BITS-1:0];
  assign res_ext  = sps_pkg::EXT_W'(cand_q);
  assign last_bit = (bit_cnt == CNT_W'(VALUE_BITS-1));
  assign chain[0] = head;
  assign tail     = chain[NUM_STAGES];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sps_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_tlast) begin
            state_next = sps_pkg::ST_DONE;
          end else if (cand_v >= VALUE_BITS'(2)) begin
            state_next = sps_pkg::ST_SHIFT;
          end
        end
      end
      sps_pkg::ST_SHIFT: begin
        if (last_bit) begin
          state_next = sps_pkg::ST_DRAIN;
        end
      end
      sps_pkg::ST_DRAIN: begin
        if (tail.vld && tail.last) begin
          state_next = tail.hit ? sps_pkg::ST_IDLE : sps_pkg::ST_DONE;
        end
      end
      sps_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = sps_pkg::ST_IDLE;
        end
      end
      default: state_next = sps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready    = 1'b0;
    load_out    = 1'b0;
    head.vld    = 1'b0;
    head.dbit   = shreg[VALUE_BITS-1];
    head.first  = (bit_cnt == '0);
    head.last   = last_bit;
    head.hit    = 1'b0;
    head.stored = 1'b0;
    case (state)
      sps_pkg::ST_IDLE:  s_tready = 1'b1;
      sps_pkg::ST_SHIFT: head.vld = 1'b1;
      sps_pkg::ST_DRAIN: ;
      sps_pkg::ST_DONE:  load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;
  assign clear  = accept && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sps_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sps_pkg::ST_IDLE: begin
        bit_cnt <= '0;
        if (accept) begin
          shreg        <= cand_v;
          cand_q       <= s_tlast ? '0 : cand_v;
          res_end      <= s_tlast;
          res_overflow <= 1'b0;
        end
      end
      sps_pkg::ST_SHIFT: begin
        shreg   <= shreg << 1;
        bit_cnt <= bit_cnt + CNT_W'(1);
      end
      sps_pkg::ST_DRAIN: begin
        if (tail.vld && tail.last) begin
          res_overflow <= !tail.stored;
          res_end      <= 1'b0;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= res_ext[15:0];
      m_tuser <= res_overflow;
      m_tlast <= res_end;
    end
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    sps_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .step_in (chain[g]),
      .step_out(chain[g+1])
    );
  end

endmodule

FILE: rtl/sps_cell.sv
`timescale 1ns / 1ps
// one sieve cell: holds one stored value and a running remainder
// depends on sps_pkg

module sps_cell #(
  parameter int VALUE_BITS = sps_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  sps_pkg::step_t step_in,
  output sps_pkg::step_t step_out
);

  logic                  valid;
  logic [VALUE_BITS-1:0] prime;
  logic [VALUE_BITS-1:0] rem;

  logic [VALUE_BITS-1:0] rem_base;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic [VALUE_BITS-1:0] rem_next;
  logic                  claim;

  always_comb begin
    rem_base = step_in.first ? '0 : rem;
    shifted  = {rem_base, step_in.dbit};
    diff     = shifted - {1'b0, prime};
    if (valid) begin
      rem_next = (shifted >= {1'b0, prime}) ? diff[VALUE_BITS-1:0]
                                             : shifted[VALUE_BITS-1:0];
    end else begin
      rem_next = shifted[VALUE_BITS-1:0];
    end
    claim = step_in.vld && step_in.last && !valid && !step_in.hit && !step_in.stored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      step_out.vld <= 1'b0;
    end else begin
      step_out.vld <= step_in.vld;
      if (clear) begin
        valid <= 1'b0;
      end else if (claim) begin
        valid <= 1'b1;
      end
    end
    if (step_in.vld) begin
      rem <= rem_next;
    end
    if (claim) begin
      prime <= rem_next;
    end
    step_out.dbit   <= step_in.dbit;
    step_out.first  <= step_in.first;
    step_out.last   <= step_in.last;
    step_out.hit    <= step_in.hit || (step_in.last && valid && (rem_next == '0));
    step_out.stored <= step_in.stored || claim;
  end

endmodule
